// ----- rtl/sstf_pkg.sv -----
// ----------------------------------------------------------------------------
// sstf_pkg
// Field widths, saturation limit and transaction payload types shared by the
// SSTF seek scheduler files.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int CYL_W   = 16;   // cylinder and distance field width
    localparam int TOTAL_W = 22;   // running seek total width

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [CYL_W-1:0] request_cylinder;
        logic             is_last_request;
    } t_req;

    typedef struct packed {
        logic [CYL_W-1:0]   served_cylinder;
        logic [CYL_W-1:0]   seek_distance;
        logic [TOTAL_W-1:0] total_seek;
        logic               overflow_flag;
        logic               is_last_served;
    } t_res;

endpackage

// ----- rtl/sstf_if.sv -----
// ----------------------------------------------------------------------------
// sstf_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface sstf_req_if;
    import sstf_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sstf_res_if;
    import sstf_pkg::*;

    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/sstf_store.sv -----
// ----------------------------------------------------------------------------
// sstf_store
// Request store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sstf_store #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/sstf_dist_unit.sv -----
// ----------------------------------------------------------------------------
// sstf_dist_unit
// Shared distance/compare unit: |cand - head| and strict-less test vs best.
// ----------------------------------------------------------------------------
module sstf_dist_unit #(
    parameter int W = 16
) (
    input  logic [W-1:0] i_cand,
    input  logic [W-1:0] i_head,
    input  logic [W-1:0] i_best,
    input  logic         i_have_best,
    output logic [W-1:0] o_dist,
    output logic         o_better
);

    always_comb begin
        o_dist   = (i_cand > i_head) ? (i_cand - i_head) : (i_head - i_cand);
        // strict compare keeps the earliest loaded entry on a tie
        o_better = !i_have_best || (o_dist < i_best);
    end

endmodule

// ----- rtl/sstf_seek_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// sstf_seek_scheduler_core
// Shortest-seek-time-first scheduler over a batch of cylinder requests.
// ----------------------------------------------------------------------------
// Requests load one per cycle while i_req.ready is high, up to MAX_REQUESTS
// entries; later ones in the same batch are dropped and every result of that
// batch carries overflow_flag. The transaction with is_last_request closes the
// batch: the head is set to the first loaded cylinder (read in S_INIT,
// captured in S_HEAD), then each service scans all n loaded entries through
// the single read port of the request store and one shared distance/compare
// unit; each result waits in S_EMIT while o_res.ready stays low. i_req.ready
// stays low from the closing transaction until the batch's last result is
// taken. Ties go to the earliest loaded entry, so equal cylinders are served
// back to back at distance zero. total_seek saturates at its 22-bit maximum;
// the head position is kept across batches but re-seeded from each batch's
// first request.
// ----------------------------------------------------------------------------
module sstf_seek_scheduler_core #(
    parameter int MAX_REQUESTS = 32,
    parameter int CYL_BITS     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sstf_req_if.sink          i_req,
    sstf_res_if.source        o_res
);
    import sstf_pkg::*;

    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int SUM_W = ((CYL_BITS > TOTAL_W) ? CYL_BITS : TOTAL_W) + 1;

    typedef enum logic [2:0] {
        S_LOAD,   // taking requests
        S_INIT,   // read entry 0 for head seed
        S_HEAD,   // capture head
        S_SCAN,   // sweep store for nearest unserved entry
        S_UPD,    // commit pick, build result
        S_EMIT    // hold result until taken
    } t_state;

    t_state r_state;

    logic [CNT_W-1:0]    r_count;     // loaded entries
    logic [CNT_W-1:0]    r_done;      // services emitted
    logic [CNT_W-1:0]    r_issue;     // next scan read address
    logic                r_cmp_valid; // read data in flight is valid
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_have;
    logic [CYL_BITS-1:0] r_best;
    logic [IDX_W-1:0]    r_pick;
    logic [CYL_BITS-1:0] r_pick_cyl;
    logic [CYL_BITS-1:0] r_head;
    logic [TOTAL_W-1:0]  r_total;
    logic                r_dropped;
    logic [MAX_REQUESTS-1:0] r_served;

    logic                r_out_valid;
    t_res                r_out;

    // store port signals
    logic                mem_wr_en;
    logic                mem_rd_en;
    logic [IDX_W-1:0]    mem_rd_addr;
    logic [CYL_BITS-1:0] mem_rd_data;
    logic [CYL_BITS-1:0] in_cyl;
    logic [CYL_BITS+CYL_W-1:0] in_ext;

    // compare unit
    logic [CYL_BITS-1:0] cand_dist;
    logic                better;

    logic                req_fire;
    logic                scan_issue;
    logic                scan_hit;
    logic                scan_end;
    logic [SUM_W-1:0]    sum;
    logic [TOTAL_W-1:0]  total_next;
    logic [CYL_BITS+CYL_W-1:0] pick_ext;
    logic [CYL_BITS+CYL_W-1:0] best_ext;

    assign in_ext = {{CYL_BITS{1'b0}}, i_req.payload.request_cylinder};
    assign in_cyl = in_ext[CYL_BITS-1:0];

    assign i_req.ready   = (r_state == S_LOAD);
    assign req_fire      = i_req.valid && i_req.ready;
    assign mem_wr_en     = req_fire && (r_count < CNT_W'(MAX_REQUESTS));

    assign scan_issue    = (r_state == S_SCAN) && (r_issue < r_count);
    assign mem_rd_en     = (r_state == S_INIT) || scan_issue;
    assign mem_rd_addr   = (r_state == S_INIT) ? '0 : r_issue[IDX_W-1:0];

    assign scan_hit      = r_cmp_valid && !r_served[r_cmp_idx] && better;
    assign scan_end      = r_cmp_valid && (r_cmp_idx == IDX_W'(r_count - 1'b1));

    // saturating running total
    assign sum        = SUM_W'(r_total) + SUM_W'(r_best);
    assign total_next = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

    // fit CYL_BITS values into the 16-bit result fields
    assign pick_ext = {{CYL_W{1'b0}}, r_pick_cyl};
    assign best_ext = {{CYL_W{1'b0}}, r_best};

    sstf_store #(
        .DEPTH (MAX_REQUESTS),
        .WIDTH (CYL_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (in_cyl),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    sstf_dist_unit #(
        .W (CYL_BITS)
    ) u_dist (
        .i_cand      (mem_rd_data),
        .i_head      (r_head),
        .i_best      (r_best),
        .i_have_best (r_have),
        .o_dist      (cand_dist),
        .o_better    (better)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_done      <= '0;
            r_issue     <= '0;
            r_cmp_valid <= 1'b0;
            r_have      <= 1'b0;
            r_head      <= '0;
            r_total     <= '0;
            r_dropped   <= 1'b0;
            r_served    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (req_fire) begin
                        if (mem_wr_en) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_req.payload.is_last_request) begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_state <= S_HEAD;
                end
                S_HEAD: begin
                    r_head      <= mem_rd_data;
                    r_issue     <= '0;
                    r_cmp_valid <= 1'b0;
                    r_have      <= 1'b0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    r_cmp_valid <= scan_issue;
                    if (scan_issue) begin
                        r_cmp_idx <= r_issue[IDX_W-1:0];
                        r_issue   <= r_issue + 1'b1;
                    end
                    if (scan_hit) begin
                        r_have     <= 1'b1;
                        r_best     <= cand_dist;
                        r_pick     <= r_cmp_idx;
                        r_pick_cyl <= mem_rd_data;
                    end
                    if (scan_end) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_served[r_pick]      <= 1'b1;
                    r_head                <= r_pick_cyl;
                    r_total               <= total_next;
                    r_done                <= r_done + 1'b1;
                    r_out.served_cylinder <= pick_ext[CYL_W-1:0];
                    r_out.seek_distance   <= best_ext[CYL_W-1:0];
                    r_out.total_seek      <= total_next;
                    r_out.overflow_flag   <= r_dropped;
                    r_out.is_last_served  <= (r_done + 1'b1 == r_count);
                    r_out_valid           <= 1'b1;
                    r_state               <= S_EMIT;
                end
                S_EMIT: begin
                    if (o_res.ready) begin
                        r_out_valid <= 1'b0;
                        r_issue     <= '0;
                        r_cmp_valid <= 1'b0;
                        r_have      <= 1'b0;
                        if (r_out.is_last_served) begin
                            // batch finished: empty the store, keep head
                            r_count   <= '0;
                            r_done    <= '0;
                            r_total   <= '0;
                            r_dropped <= 1'b0;
                            r_served  <= '0;
                            r_state   <= S_LOAD;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_res.valid)
        else $error("request taken while a result is pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(MAX_REQUESTS)) && (r_done <= r_count))
        else $error("load or service count out of range");

    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && o_res.payload.is_last_served |=> i_req.ready)
        else $error("scheduler did not return to load after final result");

    a_pick_unserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_have && !r_served[r_pick]))
        else $error("service picked an already served entry");

endmodule

// ----- tb/tb_sstf_seek_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// tb_sstf_seek_scheduler_core
// Self-checking bench for the SSTF seek scheduler: batches of cylinder
// requests go in and every service transaction is checked against a
// shortest-seek predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_sstf_seek_scheduler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sstf_pkg::*;

    localparam int DEPTH        = 32;       // store depth given to the DUT
    localparam int HOLD_CYCLES  = 2000;     // long result back-pressure stretch
    localparam int HOLD_AT_REQ  = 60;       // start the stretch after this many requests
    localparam int DRAIN_CYCLES = 1200;     // longer than serving one full batch of DEPTH requests
    localparam int CYCLE_LIMIT  = 300000;   // watchdog
    localparam int RANDOM_ITEMS = 290;
    localparam int MAX_REPORTS  = 10;

    // How the cylinders of one batch are spread.
    typedef enum int {
        CYL_SPREAD,     // anywhere in the 16-bit range
        CYL_CLUSTER,    // tight group: duplicates and equal-distance ties
        CYL_EDGES       // near cylinder 0 and near the top cylinder
    } t_cyl_mix;

    logic i_clk;
    logic i_rst_n;

    sstf_req_if req_if();
    sstf_res_if res_if();

    sstf_seek_scheduler_core #(
        .MAX_REQUESTS (DEPTH),
        .CYL_BITS     (CYL_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------------
    // Clock and reset; the driver processes put known valid and ready values on
    // the DUT inputs at the first edge, inside reset
    // ------------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Bookkeeping (two-state, so all counters start at zero)
    // ------------------------------------------------------------------------
    t_req pending_reqs[$];          // request transactions not yet offered
    t_res expected_services[$];     // service transactions still owed by the DUT

    int unsigned req_count;         // accepted request transactions
    int unsigned svc_count;         // accepted service transactions
    int unsigned batch_count;       // batches closed
    int unsigned overflow_batches;  // batches that dropped requests
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // ------------------------------------------------------------------------
    // SSTF predictor. Mirrors the block: requests load until the store is
    // full (later ones only set the dropped flag), the closing request kicks
    // off the scan, head seeded from entry 0, strict less-than compare so the
    // earliest loaded entry wins a tie.
    // ------------------------------------------------------------------------
    logic [CYL_W-1:0] cyl_store [DEPTH];
    bit               served    [DEPTH];
    int unsigned      n_loaded;
    bit               dropped;
    logic [CYL_W-1:0] head_cyl;

    task automatic sstf_absorb(input t_req r);
        int unsigned      pick;
        int unsigned      best;
        int unsigned      gap;
        int unsigned      total;
        bit               found;
        t_res             svc;
        if (n_loaded < DEPTH) begin
            cyl_store[n_loaded] = r.request_cylinder;
            served[n_loaded]    = 1'b0;
            n_loaded++;
        end else begin
            dropped = 1'b1;
        end
        if (!r.is_last_request)
            return;

        head_cyl = cyl_store[0];
        total    = 0;
        for (int k = 0; k < n_loaded; k++) begin
            found = 1'b0;
            pick  = 0;
            best  = 0;
            for (int i = 0; i < n_loaded; i++) begin
                if (served[i])
                    continue;
                gap = (cyl_store[i] > head_cyl) ? cyl_store[i] - head_cyl
                                                : head_cyl - cyl_store[i];
                if (!found || gap < best) begin
                    found = 1'b1;
                    best  = gap;
                    pick  = i;
                end
            end
            served[pick] = 1'b1;
            head_cyl     = cyl_store[pick];
            // saturates at the 22-bit maximum; out of reach at depth 32
            total = total + best;
            if (total > TOTAL_MAX)
                total = TOTAL_MAX;
            svc.served_cylinder = head_cyl;
            svc.seek_distance   = best[CYL_W-1:0];
            svc.total_seek      = total[TOTAL_W-1:0];
            svc.overflow_flag   = dropped;
            svc.is_last_served  = (k + 1 == n_loaded);
            expected_services.push_back(svc);
        end

        batch_count++;
        if (dropped)
            overflow_batches++;
        for (int i = 0; i < DEPTH; i++)
            served[i] = 1'b0;
        n_loaded = 0;
        dropped  = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [CYL_W-1:0] pick_cylinder(t_cyl_mix mix, logic [CYL_W-1:0] base);
        logic [CYL_W-1:0] c;
        case (mix)
            CYL_CLUSTER: begin
                c = base + CYL_W'($urandom_range(0, 15));
            end
            CYL_EDGES: begin
                if ($urandom_range(0, 1))
                    c = CYL_W'($urandom_range(0, 7));
                else
                    c = {CYL_W{1'b1}} - CYL_W'($urandom_range(0, 7));
            end
            default: begin
                c = CYL_W'($urandom);
            end
        endcase
        return c;
    endfunction

    task automatic push_req(input logic [CYL_W-1:0] cyl, input bit last);
        t_req r;
        r.request_cylinder = cyl;
        r.is_last_request  = last;
        pending_reqs.push_back(r);
    endtask

    task automatic push_batch(input int unsigned n, input t_cyl_mix mix);
        logic [CYL_W-1:0] base;
        base = CYL_W'($urandom);
        for (int i = 0; i < n; i++)
            push_req(pick_cylinder(mix, base), i == n - 1);
    endtask

    // ------------------------------------------------------------------------
    // Request driver: a transaction stays on the bus until accepted; the next
    // one (or an idle) only replaces it once the current one is gone. One NBA
    // per signal per edge, so valid never drops and rises in the same step.
    // Idles about 28% of cycles except over a stretch of accepted requests.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() != 0 &&
                !($urandom_range(0, 99) < 28 && !(req_count >= 120 && req_count < 200))) begin
                req_if.valid   <= 1'b1;
                req_if.payload <= pending_reqs.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long hold-off on the result side, timed in its own process. It starts
    // once HOLD_AT_REQ requests have been accepted, while requests keep being offered, so
    // the block sits on a finished service and holds its input off.
    // ------------------------------------------------------------------------
    bit          hold_active;
    bit          hold_done;
    int unsigned hold_cnt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_active <= 1'b0;
            hold_done   <= 1'b0;
            hold_cnt    <= 0;
        end else if (!hold_done && !hold_active && req_count >= HOLD_AT_REQ) begin
            hold_active <= 1'b1;
            hold_cnt    <= 0;
        end else if (hold_active) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1) begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end
        end
    end

    // Result ready: random stalls, none over a window of services, none at all
    // during the hold-off (it is low throughout).
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= !hold_active &&
                            !($urandom_range(0, 99) < 28 &&
                              !(svc_count >= 150 && svc_count < 260));
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted request, check every accepted
    // service against the oldest expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        bit   bad;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                sstf_absorb(req_if.payload);
                req_count <= req_count + 1;
            end
            if (res_if.valid && res_if.ready) begin
                got = res_if.payload;
                svc_count <= svc_count + 1;
                if (expected_services.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] unexpected service: cyl=%0d dist=%0d %s",
                                 $realtime, got.served_cylinder, got.seek_distance,
                                 $sformatf("total=%0d ovf=%0b last=%0b", got.total_seek,
                                           got.overflow_flag, got.is_last_served));
                end else begin
                    want = expected_services.pop_front();
                    bad  = (got.served_cylinder !== want.served_cylinder) ||
                           (got.seek_distance   !== want.seek_distance)   ||
                           (got.total_seek      !== want.total_seek)      ||
                           (got.overflow_flag   !== want.overflow_flag)   ||
                           (got.is_last_served  !== want.is_last_served);
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("[%0t] service #%0d mismatch", $realtime, svc_count);
                            $display("  expected cyl=%0d dist=%0d total=%0d ovf=%0b last=%0b",
                                     want.served_cylinder, want.seek_distance,
                                     want.total_seek, want.overflow_flag, want.is_last_served);
                            $display("  actual   cyl=%0d dist=%0d total=%0d ovf=%0b last=%0b",
                                     got.served_cylinder, got.seek_distance,
                                     got.total_seek, got.overflow_flag, got.is_last_served);
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d services still owed",
                     cycle_count, expected_services.size());
            $display("tb_sstf_seek_scheduler_core NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned rand_items;
        int unsigned n;
        int unsigned roll;

        // Directed batches
        // single-request batch: served at distance zero, flagged last
        push_req(16'd1234, 1'b1);
        // extremes and a duplicate of the first entry
        push_req(16'hFFFF, 1'b0);
        push_req(16'h0000, 1'b0);
        push_req(16'hFFFF, 1'b0);
        push_req(16'h8000, 1'b1);
        // duplicate of head, then equal distance both ways: lower index wins
        push_req(16'd100, 1'b0);
        push_req(16'd90,  1'b0);
        push_req(16'd110, 1'b0);
        push_req(16'd100, 1'b1);
        // tie with the upper cylinder loaded first
        push_req(16'd500, 1'b0);
        push_req(16'd520, 1'b0);
        push_req(16'd480, 1'b1);
        // all on one cylinder
        push_req(16'd7, 1'b0);
        push_req(16'd7, 1'b0);
        push_req(16'd7, 1'b1);
        // largest single seek
        push_req(16'h0000, 1'b0);
        push_req(16'hFFFF, 1'b1);

        // Random batches. The first one overruns the store so the dropped
        // request and dropped closing request paths are exercised early.
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (rand_items == 0 || roll < 5)
                n = $urandom_range(DEPTH + 1, DEPTH + 4);
            else if (roll < 12)
                n = DEPTH;
            else if (roll < 20)
                n = $urandom_range(11, DEPTH - 1);
            else
                n = $urandom_range(1, 10);
            push_batch(n, t_cyl_mix'($urandom_range(0, 2)));
            rand_items += n;
        end

        @(posedge i_rst_n);
        while (pending_reqs.size() != 0 || req_if.valid)
            @(posedge i_clk);
        while (expected_services.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d requests in %0d batches (%0d over depth), %0d services checked",
                 req_count, batch_count, overflow_batches, svc_count);
        $display("result hold-off of %0d cycles, %0d mismatches", HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_sstf_seek_scheduler_core OK");
        else
            $display("tb_sstf_seek_scheduler_core NOT OK");
        $finish;
    end

endmodule
